>>> sv/sbs_pkg.sv
// Shared types and constants for the sorted-table binary search block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

	// Fixed field widths of the item and result ports
	localparam int CMD_W   = 1;
	localparam int ADDR_W  = 10;
	localparam int VALUE_W = 32;
	localparam int LEN_W   = 11;
	localparam int POS_W   = 10;

	// Default table size
	localparam int DEFAULT_TABLE_DEPTH = 1024;

	// Register port: byte address width and data width
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register word indexes
	localparam logic [APB_AW-3:0] REG_TABLE_LENGTH = 1'b0;

	// Item commands
	localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_PROBE,
		S_FINISH
	} sbs_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic wr_en;       // store the accepted write item
		logic init;        // load key and range from the accepted search item
		logic first_read;  // read the entry at the middle of the fresh range
		logic step;        // compare the returned entry and narrow the range
		logic set_result;  // capture the search outcome
		logic load_out;    // move the outcome into the output register
	} sbs_ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic range_empty; // current range holds no entry
		logic match;       // returned entry equals the key
		logic next_empty;  // narrowed range holds no entry
	} sbs_sts_t;

endpackage

`default_nettype wire

>>> sv/sorted_table_binary_search.sv
// Sorted-table binary search. A write item (cmd 0) stores item_value at
// entry_address; addresses at or beyond the table are dropped.
// A search item (cmd 1) looks for item_value among entries 0 to
// table_length-1 (clamped to the table size) by halving a half-open range,
// and returns one result: found and the matching position, or found 0 and
// position 0. The table memory has one read port with registered data, so a
// search makes one probe per cycle. A new item is accepted only in the idle
// state, after the previous search has handed its result to the output register.
// Entries must be written in ascending signed order before they are searched.
// table_length sits at byte address 0 of the register port and should only be
// written while no search runs. Depends on sbs_pkg, sbs_ctrl, sbs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search import sbs_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Register port
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic        [APB_AW-1:0]  paddr,
	input  wire logic        [APB_DW-1:0]  pwdata,
	output logic             [APB_DW-1:0]  prdata,
	output logic                           pready,
	// Item channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic        [CMD_W-1:0]   cmd,
	input  wire logic        [ADDR_W-1:0]  entry_address,
	input  wire logic signed [VALUE_W-1:0] item_value,
	// Result channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           found,
	output logic             [POS_W-1:0]   position
);

	logic [LEN_W-1:0]    table_length_q;
	logic [APB_AW-3:0]   reg_idx;
	sbs_ctl_t            ctl;
	sbs_sts_t            sts;

	// Register decode: word index from the byte address
	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& (reg_idx == REG_TABLE_LENGTH)) begin
			table_length_q <= pwdata[LEN_W-1:0];
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_TABLE_LENGTH: prdata = APB_DW'(table_length_q);
			default:          prdata = '0;
		endcase
	end

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.item_cmd  (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sbs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.table_length  (table_length_q),
		.entry_address (entry_address),
		.item_value    (item_value),
		.found         (found),
		.position      (position)
	);

endmodule

`default_nettype wire

>>> sv/sbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/sbs_datapath.sv
// Datapath of the binary search: key and range registers, probe compare,
// result and output registers, and the table memory. Depends on sbs_pkg, sbs_ram.
`timescale 1ns / 1ps
`default_nettype none

module sbs_datapath import sbs_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sbs_ctl_t                  ctl,
	output sbs_sts_t                       sts,
	input  wire logic        [LEN_W-1:0]   table_length,
	input  wire logic        [ADDR_W-1:0]  entry_address,
	input  wire logic signed [VALUE_W-1:0] item_value,
	output logic                           found,
	output logic             [POS_W-1:0]   position
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);

	logic signed [VALUE_W-1:0] key_q;
	logic        [LW-1:0]      low_q;
	logic        [LW-1:0]      high_q;
	logic        [AW-1:0]      mid_q;
	logic                      res_found_q;
	logic        [AW-1:0]      res_pos_q;
	logic                      found_q;
	logic        [POS_W-1:0]   position_q;

	logic        [VALUE_W-1:0] rdata_q;
	logic signed [VALUE_W-1:0] probe;
	logic                      gt;
	logic        [LW-1:0]      high_init;
	logic        [LW:0]        sum_cur;
	logic        [AW-1:0]      mid_cur;
	logic        [LW-1:0]      low_n;
	logic        [LW-1:0]      high_n;
	logic        [LW:0]        sum_n;
	logic        [AW-1:0]      mid_n;
	logic                      wr_in_range;
	logic                      rd_en;
	logic        [AW-1:0]      rd_addr;

	// Clamp the configured length to the table size
	always_comb begin
		if (32'(table_length) > 32'(TABLE_DEPTH)) begin
			high_init = LW'(TABLE_DEPTH);
		end else begin
			high_init = LW'(table_length);
		end
	end

	// Middle of the current range
	assign sum_cur = {1'b0, low_q} + {1'b0, high_q};
	assign mid_cur = AW'(sum_cur >> 1);

	// Compare the returned entry with the key and narrow the range
	assign probe     = $signed(rdata_q);
	assign gt        = probe > key_q;
	assign sts.match = probe == key_q;

	always_comb begin
		low_n  = low_q;
		high_n = high_q;
		if (gt) begin
			high_n = LW'(mid_q);
		end else begin
			low_n = LW'(mid_q) + LW'(1);
		end
	end

	assign sum_n           = {1'b0, low_n} + {1'b0, high_n};
	assign mid_n           = AW'(sum_n >> 1);
	assign sts.next_empty  = !(low_n < high_n);
	assign sts.range_empty = !(low_q < high_q);

	// Range, key and probe index registers
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			key_q  <= item_value;
			low_q  <= '0;
			high_q <= high_init;
		end else if (ctl.step) begin
			low_q  <= low_n;
			high_q <= high_n;
		end
		if (ctl.first_read) begin
			mid_q <= mid_cur;
		end else if (ctl.step && !sts.match && !sts.next_empty) begin
			mid_q <= mid_n;
		end
	end

	// Capture the outcome, then hand it to the output register
	always_ff @(posedge clk) begin
		if (ctl.set_result) begin
			res_found_q <= ctl.step && sts.match;
			res_pos_q   <= (ctl.step && sts.match) ? mid_q : '0;
		end
		if (ctl.load_out) begin
			found_q    <= res_found_q;
			position_q <= POS_W'(res_pos_q);
		end
	end

	assign found    = found_q;
	assign position = position_q;

	// Table memory: drop writes beyond the table, read one probe a cycle
	assign wr_in_range = 32'(entry_address) < 32'(TABLE_DEPTH);
	assign rd_en       = ctl.first_read || (ctl.step && !sts.match && !sts.next_empty);
	assign rd_addr     = ctl.first_read ? mid_cur : mid_n;

	sbs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ctl.wr_en && wr_in_range),
		.waddr   (AW'(entry_address)),
		.wdata   (item_value),
		.re      (rd_en),
		.raddr   (rd_addr),
		.rdata_q (rdata_q)
	);

	// The probe always lies inside the live range
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (LW'(mid_q) >= low_q) && (LW'(mid_q) < high_q))
		else $error("probe index outside search range");

	// The range shrinks on every step that continues the search
	a_range_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && !sts.match && !sts.next_empty |=>
		(32'(high_q) - 32'(low_q)) < (32'($past(high_q)) - 32'($past(low_q))))
		else $error("search range failed to shrink");

	// A first read needs a nonempty range
	a_first_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.first_read |-> !sts.range_empty)
		else $error("read issued on empty range");

endmodule

`default_nettype wire

>>> sv/sbs_ctrl.sv
// Controller of the binary search: item handshake, search sequencing and
// output valid. Depends on sbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbs_ctrl import sbs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [CMD_W-1:0] item_cmd,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire sbs_sts_t         sts,
	output sbs_ctl_t              ctl
);

	sbs_state_t state_q;
	sbs_state_t state_d;
	logic       out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (item_cmd == CMD_SEARCH) begin
						ctl.init = 1'b1;
						state_d  = S_START;
					end else begin
						ctl.wr_en = 1'b1;
					end
				end
			end
			S_START: begin
				if (sts.range_empty) begin
					ctl.set_result = 1'b1;
					state_d        = S_FINISH;
				end else begin
					ctl.first_read = 1'b1;
					state_d        = S_PROBE;
				end
			end
			S_PROBE: begin
				ctl.step = 1'b1;
				if (sts.match || sts.next_empty) begin
					ctl.set_result = 1'b1;
					state_d        = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output valid: set on load, drop when the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// Table writes happen only between searches
	a_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (state_q == S_IDLE) && in_ready)
		else $error("table write outside idle");

	// An outcome is always followed by the output hand-off state
	a_result_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_result |=> (state_q == S_FINISH))
		else $error("outcome captured without finish");

	// A search start always opens with range setup
	a_init_then_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init |=> (state_q == S_START) && !in_ready)
		else $error("search accepted without setup");

endmodule

`default_nettype wire
